@@ hdl/assert_macros.svh @@
// Assertion macros shared by the solenoid timer bank RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset
`define SPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under asynchronous active-low reset
`define SPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/spt_pkg.sv @@
// Package for the solenoid pulse timer bank: sizes, codes and shared types.
// Used by spt_sub_unit, spt_seq and solenoid_pulse_timer_bank_unit.
package spt_pkg;

	localparam int CHANNELS = 32;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);
	localparam int MASK_W   = 32;
	localparam int PAD_W    = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
	localparam int STAMP_W  = 16;
	localparam int PCOUNT_MAX = 63;

	localparam logic [CNT_W-1:0]   CH_CNT    = CNT_W'(CHANNELS);
	localparam logic [7:0]         CH_LIM    = 8'(CHANNELS);
	localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
	localparam logic [STAMP_W-1:0] STAMP_ONE = STAMP_W'(1);

	// Duty scaling: min + vel * (255 - min) / 127
	localparam logic [7:0] DUTY_FULL = 8'd255;
	localparam logic [6:0] VEL_SCALE = 7'd127;
	localparam int         DIVD_W    = 15;
	// floor(x / 127) == (x * ceil(2^22 / 127)) >> 22 for every 15-bit x
	localparam int                 RECIP_W   = 16;
	localparam int                 RECIP_SH  = 22;
	localparam int                 QPROD_W   = DIVD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] VEL_RECIP = 16'd33027;

	// Command codes
	localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_START_NOTE   = 3'd0;
	localparam logic [2:0] REG_NOTE_RANGE   = 3'd1;
	localparam logic [2:0] REG_HIT_TIME_MS  = 3'd2;
	localparam logic [2:0] REG_MIN_DUTY     = 3'd3;
	localparam logic [2:0] REG_MUTE_MANAGED = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] note;
		logic [6:0] velocity;
	} in_item_t;

	typedef struct packed {
		logic [31:0] active_mask;
		logic [7:0]  drive_duty;
		logic        mute_on;
		logic [5:0]  pulsing_count;
		logic [7:0]  held_count;
		logic        note_in_range;
	} out_item_t;

	typedef struct packed {
		logic [6:0] start_note;
		logic [5:0] note_range;
		logic [7:0] hit_time_ms;
		logic [7:0] min_duty;
		logic       mute_managed;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] a;
		logic [STAMP_W-1:0] b;
		logic [STAMP_W-1:0] lim;
	} unit_req_t;

	typedef struct packed {
		logic [STAMP_W:0] diff;
		logic             ge;
	} unit_rsp_t;

endpackage

@@ hdl/spt_sub_unit.sv @@
// Shared subtract-and-compare unit: diff = a - b with borrow, ge = diff without borrow >= lim.
// Depends on spt_pkg; serves the pulse age scan.
module spt_sub_unit (
	input  spt_pkg::unit_req_t req,
	output spt_pkg::unit_rsp_t rsp
);

	logic [spt_pkg::STAMP_W:0] diff;

	assign diff     = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff = diff;
	assign rsp.ge   = (diff[spt_pkg::STAMP_W-1:0] >= req.lim);

endmodule

@@ hdl/spt_seq.sv @@
// Sequencer and state of the timer bank: channel map, stamp memory, counters,
// reciprocal duty scaling and per-tick age scan. Depends on spt_pkg, spt_sub_unit.
module spt_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  spt_pkg::in_item_t   item,
	input  spt_pkg::cfg_t       cfg,
	input  logic                slot_free,
	output logic                idle,
	output logic                done,
	output spt_pkg::out_item_t  result
);

	spt_pkg::state_t state_q, state_d;

	logic [1:0] cmd_q;
	logic [6:0] note_q;
	logic [6:0] vel_q;

	logic [spt_pkg::STAMP_W-1:0] now_q;
	logic [spt_pkg::CHANNELS-1:0] on_q;
	logic [spt_pkg::CNT_W-1:0]    pulsing_q;
	logic [7:0] held_q;
	logic       muted_q;
	logic [7:0] duty_q;
	logic       in_range_q;

	logic [spt_pkg::DIVD_W-1:0] x_q;

	logic [spt_pkg::CNT_W-1:0] scan_q;
	logic                      v_s1;
	logic [spt_pkg::IDX_W-1:0] idx_s1;

	logic [spt_pkg::STAMP_W-1:0] stamp_mem [spt_pkg::CHANNELS];
	logic [spt_pkg::STAMP_W-1:0] rdata_q;

	logic dec_en, div_en, scan_issue;

	// Range test and channel index
	logic [7:0] off;
	logic       in_rng;
	logic [spt_pkg::IDX_W-1:0] ch;

	assign off    = {1'b0, note_q} - {1'b0, cfg.start_note};
	assign in_rng = !off[7] && (off[6:0] < {1'b0, cfg.note_range})
		&& ({1'b0, off[6:0]} < spt_pkg::CH_LIM);
	assign ch     = off[spt_pkg::IDX_W-1:0];

	// Duty product
	logic [7:0]  span_d;
	logic [spt_pkg::DIVD_W-1:0] prod_d;

	assign span_d = spt_pkg::DUTY_FULL - cfg.min_duty;
	assign prod_d = {8'b0, vel_q} * {7'b0, span_d};

	// Divide the registered product by 127 through its reciprocal
	logic [spt_pkg::QPROD_W-1:0] qprod;
	logic [7:0]                  q_d;

	assign qprod = {{spt_pkg::RECIP_W{1'b0}}, x_q}
		* {{spt_pkg::DIVD_W{1'b0}}, spt_pkg::VEL_RECIP};
	assign q_d   = qprod[spt_pkg::RECIP_SH +: 8];

	// Shared unit
	spt_pkg::unit_req_t req;
	spt_pkg::unit_rsp_t rsp;
	logic [7:0] held_dec;
	logic       expire;

	assign held_dec = (held_q == 8'd0) ? 8'd0 : held_q - 8'd1;
	assign expire   = v_s1 && on_q[idx_s1] && rsp.ge;

	assign req.a   = now_q;
	assign req.b   = rdata_q;
	assign req.lim = {8'b0, cfg.hit_time_ms};

	spt_sub_unit u_sub (
		.req (req),
		.rsp (rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spt_pkg::ST_IDLE: begin
				if (start)
					state_d = spt_pkg::ST_DECODE;
			end
			spt_pkg::ST_DECODE: begin
				case (cmd_q)
					spt_pkg::CMD_NOTE_ON: state_d = in_rng ? spt_pkg::ST_DIV : spt_pkg::ST_FIN;
					spt_pkg::CMD_TICK:    state_d = spt_pkg::ST_SCAN;
					default:              state_d = spt_pkg::ST_FIN;
				endcase
			end
			spt_pkg::ST_DIV: begin
				state_d = spt_pkg::ST_FIN;
			end
			spt_pkg::ST_SCAN: begin
				// last read is being retired this cycle
				if (!scan_issue)
					state_d = spt_pkg::ST_FIN;
			end
			spt_pkg::ST_FIN: begin
				if (slot_free)
					state_d = spt_pkg::ST_IDLE;
			end
			default: state_d = spt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		idle       = (state_q == spt_pkg::ST_IDLE);
		dec_en     = (state_q == spt_pkg::ST_DECODE);
		div_en     = (state_q == spt_pkg::ST_DIV);
		scan_issue = (state_q == spt_pkg::ST_SCAN) && (scan_q != spt_pkg::CH_CNT);
		done       = (state_q == spt_pkg::ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= spt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= item.cmd;
			note_q <= item.note;
			vel_q  <= item.velocity;
		end
	end

	// Stamp memory: written on note-on, read once per channel during the scan
	always_ff @(posedge clk) begin
		if (dec_en && cmd_q == spt_pkg::CMD_NOTE_ON && in_rng)
			stamp_mem[ch] <= now_q;
		rdata_q <= stamp_mem[scan_q[spt_pkg::IDX_W-1:0]];
	end

	// Duty product register and scan datapath
	always_ff @(posedge clk) begin
		if (dec_en)
			x_q <= prod_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			v_s1   <= 1'b0;
			idx_s1 <= '0;
		end else begin
			v_s1   <= scan_issue;
			idx_s1 <= scan_q[spt_pkg::IDX_W-1:0];
			if (dec_en)
				scan_q <= '0;
			else if (scan_issue)
				scan_q <= scan_q + spt_pkg::CNT_ONE;
		end
	end

	// Bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			on_q       <= '0;
			pulsing_q  <= '0;
			held_q     <= '0;
			muted_q    <= 1'b1;
			duty_q     <= '0;
			in_range_q <= 1'b0;
		end else if (dec_en) begin
			case (cmd_q)
				spt_pkg::CMD_NOTE_ON: begin
					in_range_q <= in_rng;
					if (in_rng) begin
						muted_q <= 1'b0;
						if (!on_q[ch]) begin
							on_q[ch]  <= 1'b1;
							pulsing_q <= pulsing_q + spt_pkg::CNT_ONE;
						end
						if (held_q != spt_pkg::DUTY_FULL)
							held_q <= held_q + 8'd1;
					end
				end
				spt_pkg::CMD_NOTE_OFF: begin
					in_range_q <= in_rng;
					held_q     <= held_dec;
					if (cfg.mute_managed && held_dec == 8'd0)
						muted_q <= 1'b1;
				end
				spt_pkg::CMD_TICK: begin
					in_range_q <= 1'b0;
					now_q      <= now_q + spt_pkg::STAMP_ONE;
				end
				default: in_range_q <= 1'b0;
			endcase
		end else if (div_en) begin
			duty_q <= cfg.min_duty + q_d;
		end else if (expire) begin
			// drop the pulse once its age reaches the hit time
			on_q[idx_s1] <= 1'b0;
			pulsing_q    <= pulsing_q - spt_pkg::CNT_ONE;
		end
	end

	// Result view
	logic [spt_pkg::PAD_W-1:0] on_pad;

	assign on_pad = spt_pkg::PAD_W'(on_q);

	always_comb begin
		result.active_mask   = on_pad[spt_pkg::MASK_W-1:0];
		result.drive_duty    = duty_q;
		result.mute_on       = muted_q;
		result.pulsing_count = (int'(pulsing_q) > spt_pkg::PCOUNT_MAX)
			? 6'(spt_pkg::PCOUNT_MAX) : 6'(pulsing_q);
		result.held_count    = held_q;
		result.note_in_range = in_range_q;
	end

endmodule

@@ hdl/solenoid_pulse_timer_bank_unit.sv @@
// Path from input transaction to result valid: note-off, out-of-range note-on and
// unused commands pass decode and finish; an in-range note-on adds one duty scaling
// step; a tick scans the stamps, one stamp read per channel on the shared subtractor.
// A new item is taken once the sequencer is idle, which waits for a free output slot;
// the previous result may still wait in the output register meanwhile.
// Reset: channels idle, counts and duty zero, mute engaged, registers at defaults.
module solenoid_pulse_timer_bank_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spt_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output spt_pkg::out_item_t  out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

`include "assert_macros.svh"

	spt_pkg::cfg_t      cfg_q;
	spt_pkg::out_item_t out_item_q;
	spt_pkg::out_item_t seq_result;
	logic               out_valid_q;
	logic               seq_idle;
	logic               seq_done;
	logic               slot_free;
	logic               count_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = seq_idle;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_note   <= 7'd0;
			cfg_q.note_range   <= 6'd32;
			cfg_q.hit_time_ms  <= 8'd20;
			cfg_q.min_duty     <= 8'd0;
			cfg_q.mute_managed <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spt_pkg::REG_START_NOTE:   cfg_q.start_note   <= cfg_data[6:0];
				spt_pkg::REG_NOTE_RANGE:   cfg_q.note_range   <= cfg_data[5:0];
				spt_pkg::REG_HIT_TIME_MS:  cfg_q.hit_time_ms  <= cfg_data;
				spt_pkg::REG_MIN_DUTY:     cfg_q.min_duty     <= cfg_data;
				spt_pkg::REG_MUTE_MANAGED: cfg_q.mute_managed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	spt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.item      (in_item),
		.cfg       (cfg_q),
		.slot_free (slot_free),
		.idle      (seq_idle),
		.done      (seq_done),
		.result    (seq_result)
	);

	// Output register: hold the result until its transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (seq_done)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (seq_done)
			out_item_q <= seq_result;
	end

	assign count_ok = (spt_pkg::CHANNELS > 32)
		|| (int'(out_item_q.pulsing_count) == $countones(out_item_q.active_mask));

	`SPT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`SPT_ASSERT_IMP(a_done_into_free_slot, clk, arst_n, seq_done, !out_valid_q || out_ready)
	`SPT_ASSERT_IMP(a_count_matches_mask, clk, arst_n, out_valid_q, count_ok)

endmodule
